@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every rising clock edge outside reset.
`define MH_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define MH_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/mh_pkg.sv @@
// ----------------------------------------------------------------------------
// mh_pkg
// Types, widths and constants of the magnetometer heading pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mh_pkg;

    // field widths
    localparam int IN_W   = 16;
    localparam int D_W    = 17;
    localparam int COEF_W = 16;
    localparam int PROD_W = 33;
    localparam int SUM_W  = 36;
    localparam int OUT_W  = 18;
    localparam int HEAD_W = 16;
    localparam int REG_W  = 48;
    localparam int DECL_W = 16;

    // saturation limits of the corrected vector
    localparam logic signed [SUM_W-1:0] SAT_HI = 36'sd131071;
    localparam logic signed [SUM_W-1:0] SAT_LO = -36'sd131072;

    // CORDIC datapath: x,y are corrected * 64 with gain headroom,
    // angle in 1/256 of a hundredth of a degree
    localparam int XY_W  = 27;
    localparam int Z_W   = 25;
    localparam int PRE_SHIFT = 6;
    localparam logic signed [Z_W-1:0] Z_HALF_TURN = 25'sd4608000;
    localparam logic signed [Z_W-1:0] Z_RND       = 25'sd128;
    localparam int Z_FRAC = 8;

    // heading wrap: sum is biased by two turns so it stays non-negative
    localparam int HS_W = 20;
    localparam int T_W  = 18;
    localparam logic signed [HS_W-1:0] WRAP_OFS = 20'sd72000;
    localparam logic [T_W-1:0] TURN1 = 18'd36000;
    localparam logic [T_W-1:0] TURN2 = 18'd72000;
    localparam logic [T_W-1:0] TURN3 = 18'd108000;
    localparam logic [HEAD_W-1:0] TURN_HUND = 16'd36000;

    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_W = 21;
    localparam logic [ATAN_W-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
        21'd1152000, 21'd680065, 21'd359328, 21'd182400, 21'd91554, 21'd45822,
        21'd22916,   21'd11459,  21'd5730,   21'd2865,   21'd1432,  21'd716,
        21'd358,     21'd179,    21'd90,     21'd45,     21'd22,    21'd11,
        21'd6,       21'd3,      21'd1,      21'd1,      21'd0,     21'd0
    };

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIAS  = 3'd0,
        CFG_ROW_X = 3'd1,
        CFG_ROW_Y = 3'd2,
        CFG_ROW_Z = 3'd3,
        CFG_DECL  = 3'd4
    } cfg_idx_t;

    localparam logic [REG_W-1:0]  BIAS_RST  = 48'h0000_0000_0000;
    localparam logic [REG_W-1:0]  ROW_X_RST = 48'h0000_0000_4000;
    localparam logic [REG_W-1:0]  ROW_Y_RST = 48'h0000_4000_0000;
    localparam logic [REG_W-1:0]  ROW_Z_RST = 48'h4000_0000_0000;
    localparam logic [DECL_W-1:0] DECL_RST  = 16'd41;

    typedef struct packed {
        logic [REG_W-1:0]         bias;
        logic [REG_W-1:0]         row_x;
        logic [REG_W-1:0]         row_y;
        logic [REG_W-1:0]         row_z;
        logic signed [DECL_W-1:0] decl;
    } cfg_t;

    typedef struct packed {
        logic                    valid;
        logic signed [OUT_W-1:0] cz;
        logic signed [OUT_W-1:0] cy;
        logic signed [OUT_W-1:0] cx;
    } vec_t;

    typedef struct packed {
        logic [HEAD_W-1:0]       heading;
        logic signed [OUT_W-1:0] cz;
        logic signed [OUT_W-1:0] cy;
        logic signed [OUT_W-1:0] cx;
    } res_t;

    typedef struct packed {
        logic out_valid;
        logic full;
    } skid_stat_t;

endpackage

`default_nettype wire

@@ design/mh_correct.sv @@
// ----------------------------------------------------------------------------
// mh_correct
// Hard-iron subtract, soft-iron matrix multiply, round and saturate.
// Three register stages: difference, products, row sums.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mh_correct #(
    parameter int COEF_FRAC_BITS = 14
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           en,
    input  wire logic                           in_valid,
    input  wire logic signed [mh_pkg::IN_W-1:0] raw_x,
    input  wire logic signed [mh_pkg::IN_W-1:0] raw_y,
    input  wire logic signed [mh_pkg::IN_W-1:0] raw_z,
    input  wire mh_pkg::cfg_t                   cfg,
    output mh_pkg::vec_t                        out_vec
);

    localparam int D_W    = mh_pkg::D_W;
    localparam int PROD_W = mh_pkg::PROD_W;
    localparam int SUM_W  = mh_pkg::SUM_W;
    localparam int OUT_W  = mh_pkg::OUT_W;
    localparam int COEF_W = mh_pkg::COEF_W;
    localparam logic signed [SUM_W-1:0] ROUND = SUM_W'(1) << (COEF_FRAC_BITS - 1);

    logic signed [mh_pkg::IN_W-1:0] raw   [3];
    logic [mh_pkg::REG_W-1:0]       rows  [3];
    logic signed [D_W-1:0]          d_next  [3];
    logic signed [D_W-1:0]          d_reg   [3];
    logic signed [PROD_W-1:0]       prod_next [3][3];
    logic signed [PROD_W-1:0]       prod_reg  [3][3];
    logic signed [OUT_W-1:0]        cor_next [3];
    logic signed [OUT_W-1:0]        cor_reg  [3];
    logic v1_reg, v2_reg, v3_reg;

    assign raw[0]  = raw_x;
    assign raw[1]  = raw_y;
    assign raw[2]  = raw_z;
    assign rows[0] = cfg.row_x;
    assign rows[1] = cfg.row_y;
    assign rows[2] = cfg.row_z;

    // stage 1: exact 17-bit difference
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d_next[k] = D_W'(raw[k]) - D_W'($signed(cfg.bias[16*k +: 16]));
        end
    end

    // stage 2: nine products
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                prod_next[r][c] = $signed(rows[r][COEF_W*c +: COEF_W]) * d_reg[c];
            end
        end
    end

    // stage 3: row sum, round half up, saturate
    always_comb begin
        logic signed [SUM_W-1:0] acc;
        logic signed [SUM_W-1:0] shr;
        for (int r = 0; r < 3; r++) begin
            acc = SUM_W'(prod_reg[r][0]) + SUM_W'(prod_reg[r][1])
                + SUM_W'(prod_reg[r][2]) + ROUND;
            shr = acc >>> COEF_FRAC_BITS;
            if (shr > mh_pkg::SAT_HI) begin
                cor_next[r] = OUT_W'(mh_pkg::SAT_HI);
            end else if (shr < mh_pkg::SAT_LO) begin
                cor_next[r] = OUT_W'(mh_pkg::SAT_LO);
            end else begin
                cor_next[r] = OUT_W'(shr);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg    <= d_next;
            prod_reg <= prod_next;
            cor_reg  <= cor_next;
        end
    end

    assign out_vec.valid = v3_reg;
    assign out_vec.cx    = cor_reg[0];
    assign out_vec.cy    = cor_reg[1];
    assign out_vec.cz    = cor_reg[2];

endmodule

`default_nettype wire

@@ design/mh_cordic.sv @@
// ----------------------------------------------------------------------------
// mh_cordic
// Unrolled vectoring CORDIC for atan2(cy, cx), one iteration per stage,
// then conversion to hundredths, declination add and wrap to 0..35999.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mh_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             en,
    input  wire mh_pkg::vec_t                     in_vec,
    input  wire logic signed [mh_pkg::DECL_W-1:0] decl,
    output logic                                  res_valid,
    output mh_pkg::res_t                          res
);

    localparam int NSTEP = (CORDIC_STEPS < mh_pkg::ATAN_ENTRIES) ?
                           CORDIC_STEPS : mh_pkg::ATAN_ENTRIES;
    localparam int XY_W  = mh_pkg::XY_W;
    localparam int Z_W   = mh_pkg::Z_W;
    localparam int OUT_W = mh_pkg::OUT_W;
    localparam int HS_W  = mh_pkg::HS_W;
    localparam int T_W   = mh_pkg::T_W;
    localparam int CV_W  = 3 * OUT_W;
    localparam int EXT_W = XY_W - OUT_W - mh_pkg::PRE_SHIFT;

    logic signed [XY_W-1:0] x_reg    [NSTEP+1];
    logic signed [XY_W-1:0] y_reg    [NSTEP+1];
    logic signed [Z_W-1:0]  z_reg    [NSTEP+1];
    logic                   v_reg    [NSTEP+1];
    logic                   zero_reg [NSTEP+1];
    logic [CV_W-1:0]        cv_reg   [NSTEP+1];

    logic signed [XY_W-1:0] x_pre_next, y_pre_next;
    logic signed [Z_W-1:0]  z_pre_next;
    logic                   zero_next;
    logic [CV_W-1:0]        cv_next;

    // pre-rotation into the right half plane
    always_comb begin
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;
        xs = {{EXT_W{in_vec.cx[OUT_W-1]}}, in_vec.cx, {mh_pkg::PRE_SHIFT{1'b0}}};
        ys = {{EXT_W{in_vec.cy[OUT_W-1]}}, in_vec.cy, {mh_pkg::PRE_SHIFT{1'b0}}};
        if (in_vec.cx[OUT_W-1]) begin
            x_pre_next = -xs;
            y_pre_next = -ys;
            z_pre_next = mh_pkg::Z_HALF_TURN;
        end else begin
            x_pre_next = xs;
            y_pre_next = ys;
            z_pre_next = '0;
        end
        zero_next = (in_vec.cx == '0) && (in_vec.cy == '0);
        cv_next   = {in_vec.cz, in_vec.cy, in_vec.cx};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_vec.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= x_pre_next;
            y_reg[0]    <= y_pre_next;
            z_reg[0]    <= z_pre_next;
            zero_reg[0] <= zero_next;
            cv_reg[0]   <= cv_next;
        end
    end

    for (genvar i = 0; i < NSTEP; i++) begin : g_step
        logic signed [XY_W-1:0] xsh, ysh, x_next, y_next;
        logic signed [Z_W-1:0]  atan_v, z_next;

        always_comb begin
            xsh    = x_reg[i] >>> i;
            ysh    = y_reg[i] >>> i;
            atan_v = Z_W'(mh_pkg::ATAN_TAB[i]);
            // rotate clockwise while y is strictly positive
            if (!y_reg[i][XY_W-1] && (y_reg[i] != '0)) begin
                x_next = x_reg[i] + ysh;
                y_next = y_reg[i] - xsh;
                z_next = z_reg[i] + atan_v;
            end else begin
                x_next = x_reg[i] - ysh;
                y_next = y_reg[i] + xsh;
                z_next = z_reg[i] - atan_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                z_reg[i+1]    <= z_next;
                zero_reg[i+1] <= zero_reg[i];
                cv_reg[i+1]   <= cv_reg[i];
            end
        end
    end

    // round to hundredths, add declination, bias by two turns
    logic [T_W-1:0]  t_next, t_reg;
    logic [CV_W-1:0] cvt_reg;
    logic            vt_reg;

    always_comb begin
        logic signed [Z_W-1:0]  z_rnd;
        logic signed [HS_W-1:0] ang;
        logic signed [HS_W-1:0] h_sum;
        z_rnd  = (z_reg[NSTEP] + mh_pkg::Z_RND) >>> mh_pkg::Z_FRAC;
        ang    = zero_reg[NSTEP] ? '0 : HS_W'(z_rnd);
        h_sum  = ang + HS_W'(decl) + mh_pkg::WRAP_OFS;
        t_next = T_W'(h_sum);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vt_reg <= 1'b0;
        end else if (en) begin
            vt_reg <= v_reg[NSTEP];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg   <= t_next;
            cvt_reg <= cv_reg[NSTEP];
        end
    end

    // wrap: t lies below four turns
    always_comb begin
        logic [T_W-1:0] w;
        if (t_reg >= mh_pkg::TURN3) begin
            w = t_reg - mh_pkg::TURN3;
        end else if (t_reg >= mh_pkg::TURN2) begin
            w = t_reg - mh_pkg::TURN2;
        end else if (t_reg >= mh_pkg::TURN1) begin
            w = t_reg - mh_pkg::TURN1;
        end else begin
            w = t_reg;
        end
        res.heading = mh_pkg::HEAD_W'(w);
        res.cx      = cvt_reg[0 +: OUT_W];
        res.cy      = cvt_reg[OUT_W +: OUT_W];
        res.cz      = cvt_reg[2*OUT_W +: OUT_W];
    end

    assign res_valid = vt_reg;

endmodule

`default_nettype wire

@@ design/mh_skid.sv @@
// ----------------------------------------------------------------------------
// mh_skid
// Output register with one skid entry; stalls the pipeline only when
// the skid entry is occupied.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mh_skid (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    input  wire mh_pkg::res_t in_data,
    input  wire logic         m_ready,
    output logic              m_valid,
    output mh_pkg::res_t      m_data,
    output logic              en,
    output mh_pkg::skid_stat_t stat
);

    logic         out_v_reg, out_v_next;
    logic         sk_v_reg, sk_v_next;
    mh_pkg::res_t out_d_reg, out_d_next;
    mh_pkg::res_t sk_d_reg, sk_d_next;

    always_comb begin
        out_v_next = out_v_reg;
        out_d_next = out_d_reg;
        sk_v_next  = sk_v_reg;
        sk_d_next  = sk_d_reg;
        if (out_v_reg && !m_ready) begin
            // output stalled: park the arriving request
            if (in_valid && !sk_v_reg) begin
                sk_v_next = 1'b1;
                sk_d_next = in_data;
            end
        end else begin
            if (sk_v_reg) begin
                out_v_next = 1'b1;
                out_d_next = sk_d_reg;
                sk_v_next  = 1'b0;
            end else begin
                out_v_next = in_valid;
                out_d_next = in_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
            sk_v_reg  <= 1'b0;
        end else begin
            out_v_reg <= out_v_next;
            sk_v_reg  <= sk_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_d_reg <= out_d_next;
        sk_d_reg  <= sk_d_next;
    end

    assign m_valid        = out_v_reg;
    assign m_data         = out_d_reg;
    assign en             = !sk_v_reg;
    assign stat.out_valid = out_v_reg;
    assign stat.full      = sk_v_reg;

endmodule

`default_nettype wire

@@ design/magnetometer_heading.sv @@
// ----------------------------------------------------------------------------
// magnetometer_heading
// Hard/soft-iron corrected magnetometer vector and compass heading.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  s_       | in        | s_tvalid / s_tready  | s_tdata: raw x, y, z
//  m_       | out       | m_tvalid / m_tready  | m_tdata: corrected x, y, z, heading
//  cfg_     | in        | cfg_valid / cfg_ready| cfg_addr, cfg_data
//
//  One sample per cycle while s_tready is high; m_tvalid follows an accept through
//  the 3 correction stages, pre-rotation, one stage per CORDIC iteration, the
//  angle/declination stage and the output register.
//  Reset clears valid bits and loads the identity matrix, zero bias, 0.41 deg.
//  A stalled output parks one request in a skid entry; s_tready drops only
//  while that entry is occupied. cfg_ready is always high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module magnetometer_heading #(
    parameter int CORDIC_STEPS   = 16,
    parameter int COEF_FRAC_BITS = 14
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // raw_x [15:0], raw_y [31:16], raw_z [47:32]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // corrected_x [17:0], corrected_y [35:18],
                                        // corrected_z [53:36], heading [69:54], zero
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [mh_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [mh_pkg::REG_W-1:0]     cfg_data
);

    mh_pkg::cfg_t       cfg_reg;
    mh_pkg::vec_t       cor_vec;
    mh_pkg::res_t       pipe_res;
    mh_pkg::res_t       out_res;
    mh_pkg::skid_stat_t skid_stat;
    logic               pipe_valid;
    logic               en;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bias  <= mh_pkg::BIAS_RST;
            cfg_reg.row_x <= mh_pkg::ROW_X_RST;
            cfg_reg.row_y <= mh_pkg::ROW_Y_RST;
            cfg_reg.row_z <= mh_pkg::ROW_Z_RST;
            cfg_reg.decl  <= mh_pkg::DECL_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (mh_pkg::cfg_idx_t'(cfg_addr))
                mh_pkg::CFG_BIAS:  cfg_reg.bias  <= cfg_data;
                mh_pkg::CFG_ROW_X: cfg_reg.row_x <= cfg_data;
                mh_pkg::CFG_ROW_Y: cfg_reg.row_y <= cfg_data;
                mh_pkg::CFG_ROW_Z: cfg_reg.row_z <= cfg_data;
                mh_pkg::CFG_DECL:  cfg_reg.decl  <= cfg_data[mh_pkg::DECL_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = en;

    mh_correct #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_correct (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .raw_x    (s_tdata[15:0]),
        .raw_y    (s_tdata[31:16]),
        .raw_z    (s_tdata[47:32]),
        .cfg      (cfg_reg),
        .out_vec  (cor_vec)
    );

    mh_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_vec    (cor_vec),
        .decl      (cfg_reg.decl),
        .res_valid (pipe_valid),
        .res       (pipe_res)
    );

    mh_skid u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (pipe_valid),
        .in_data  (pipe_res),
        .m_ready  (m_tready),
        .m_valid  (m_tvalid),
        .m_data   (out_res),
        .en       (en),
        .stat     (skid_stat)
    );

    assign m_tdata = {2'b00, out_res.heading, out_res.cz, out_res.cy, out_res.cx};

    // heading always wrapped into one turn
    `MH_ASSERT(a_heading_range, aclk, aresetn, !m_tvalid || (out_res.heading < mh_pkg::TURN_HUND), "heading out of range")
    // skid entry only fills behind a held output
    `MH_ASSERT(a_skid_behind_out, aclk, aresetn, !skid_stat.full || skid_stat.out_valid, "skid full with empty output")
    // a taken output drains the skid entry at once
    `MH_ASSERT_NEXT(a_skid_drain, aclk, aresetn, skid_stat.full && m_tready, !skid_stat.full, "skid entry not drained")
    // zero vector gives the wrapped declination
    `MH_ASSERT(a_zero_vec, aclk, aresetn, !(m_tvalid && (out_res.cx == '0) && (out_res.cy == '0)) || (cfg_reg.decl[15] ? (out_res.heading == 16'(cfg_reg.decl + 16'd36000)) : (out_res.heading == cfg_reg.decl)), "zero vector heading wrong")

endmodule

`default_nettype wire
